/* rtl/cbmi_pkg.sv */
// Package for the cartridge bank mapper with scanline IRQ.
// Holds the bank and decode constants, the mirroring codes and the stream layout.
// Has no dependencies; the top level refers to it by scoped names.
package cbmi_pkg;

    // Number of 8K program banks on the cartridge.
    localparam int PRG_BANKS_8K = 32;

    // Program bank at C000 after reset: the second to last 8K bank.
    localparam logic [7:0] PRG_HIGH_RESET = 8'(PRG_BANKS_8K - 2);

    // Prescaler period, and the largest clock advance step that is honored.
    localparam logic [7:0] PRESCALE_PERIOD = 8'h72;
    localparam logic [6:0] CYCLES_MAX      = 7'd113;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;

    // Address decode mask and the decoded register addresses.
    localparam logic [15:0] ADDR_MASK     = 16'hF003;
    localparam logic [15:0] ADDR_PRG_LOW  = 16'h8000;
    localparam logic [15:0] ADDR_MIRROR   = 16'hB003;
    localparam logic [15:0] ADDR_PRG_HIGH = 16'hC000;
    localparam logic [15:0] ADDR_CHR_0    = 16'hD000;
    localparam logic [15:0] ADDR_CHR_2    = 16'hD001;
    localparam logic [15:0] ADDR_CHR_1    = 16'hD002;
    localparam logic [15:0] ADDR_CHR_3    = 16'hD003;
    localparam logic [15:0] ADDR_CHR_4    = 16'hE000;
    localparam logic [15:0] ADDR_CHR_6    = 16'hE001;
    localparam logic [15:0] ADDR_CHR_5    = 16'hE002;
    localparam logic [15:0] ADDR_CHR_7    = 16'hE003;
    localparam logic [15:0] ADDR_IRQ_LATCH = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_ACK   = 16'hF001;
    localparam logic [15:0] ADDR_IRQ_CTRL  = 16'hF002;

    // Mirroring select values, taken from the data byte masked to seven bits.
    localparam logic [6:0] MIR_SEL_VERT    = 7'h20;
    localparam logic [6:0] MIR_SEL_HORIZ   = 7'h24;
    localparam logic [6:0] MIR_SEL_LOW     = 7'h28;
    localparam logic [6:0] MIR_SEL_HIGH_A  = 7'h08;
    localparam logic [6:0] MIR_SEL_HIGH_B  = 7'h2C;

    // Command kinds carried in the input tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CLOCK = 1'b1;

    // Mirroring modes.
    typedef enum logic [1:0] {
        MIRROR_VERT   = 2'd0,
        MIRROR_HORIZ  = 2'd1,
        MIRROR_LOW    = 2'd2,
        MIRROR_HIGH   = 2'd3
    } mirror_t;

    // Stream widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;

endpackage

/* rtl/cartridge_bank_mapper_irq.sv */
// Top level of the cartridge bank mapper with the scanline IRQ; depends on cbmi_pkg.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while the result side takes its beats.
// The output register sets that figure; the state update is a single decode pass.
// Reset (rst_n, asynchronous, active low) clears the IRQ logic, loads the
// default banks and vertical mirroring, and empties the output register.
module cartridge_bank_mapper_irq
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: header mirroring, 0 vertical, 1 horizontal.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0 up: address[15:0], data[23:16], cycles[30:24], zero pad.
    input  logic [cbmi_pkg::IN_DATA_W-1:0] s_tdata,
    // s_tuser: cmd (0 register write, 1 clock advance).
    input  logic        s_tuser,

    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0 up: irq_line[0], prg_bank_16k[8:1], prg_bank_c000[16:9],
    // mirror_mode[18:17], chr_bank_a[26:19], chr_bank_b[34:27], chr_bank_c[42:35],
    // chr_bank_d[50:43], chr_bank_e[58:51], chr_bank_f[66:59], chr_bank_g[74:67],
    // chr_bank_h[82:75], zero pad.
    output logic [cbmi_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Mapper state.
    logic [1:0]            irq_mode_reg,       irq_mode_next;
    logic [7:0]            irq_count_reg,      irq_count_next;
    logic [7:0]            irq_reload_reg,     irq_reload_next;
    logic [7:0]            prescale_count_reg, prescale_count_next;
    logic                  irq_level_reg,      irq_level_next;
    logic [7:0]            prg_low_reg,        prg_low_next;
    logic [7:0]            prg_high_reg,       prg_high_next;
    logic [7:0]            chr_bank_reg [8];
    logic [7:0]            chr_bank_next [8];
    cbmi_pkg::mirror_t     mirror_reg,         mirror_next;

    // Output register.
    logic                  out_valid_reg;
    logic [cbmi_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Decoded input fields.
    logic                  in_accept;
    logic [15:0]           in_address;
    logic [7:0]            in_data;
    logic [6:0]            in_cycles;
    logic [6:0]            cycles_clamped;
    logic [15:0]           addr_sel;
    logic [6:0]            mirror_sel;
    logic [7:0]            prescale_sum;

    assign in_address = s_tdata[15:0];
    assign in_data    = s_tdata[23:16];
    assign in_cycles  = s_tdata[30:24];

    // The output register can take a new beat when empty or being drained.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign addr_sel       = in_address & cbmi_pkg::ADDR_MASK;
    assign mirror_sel     = in_data[6:0];
    assign cycles_clamped = (in_cycles > cbmi_pkg::CYCLES_MAX) ? cbmi_pkg::CYCLES_MAX
                                                               : in_cycles;
    assign prescale_sum   = prescale_count_reg + {1'b0, cycles_clamped};

    // Next state for one accepted beat: a register write or a clock advance.
    always_comb
    begin
        irq_mode_next       = irq_mode_reg;
        irq_count_next      = irq_count_reg;
        irq_reload_next     = irq_reload_reg;
        prescale_count_next = prescale_count_reg;
        irq_level_next      = irq_level_reg;
        prg_low_next        = prg_low_reg;
        prg_high_next       = prg_high_reg;
        chr_bank_next       = chr_bank_reg;
        mirror_next         = mirror_reg;

        if (s_tuser == cbmi_pkg::CMD_WRITE)
        begin
            case (addr_sel)
                cbmi_pkg::ADDR_PRG_LOW:  prg_low_next = in_data;
                cbmi_pkg::ADDR_MIRROR:
                begin
                    case (mirror_sel) inside
                        cbmi_pkg::MIR_SEL_HIGH_A,
                        cbmi_pkg::MIR_SEL_HIGH_B: mirror_next = cbmi_pkg::MIRROR_HIGH;
                        cbmi_pkg::MIR_SEL_VERT:   mirror_next = cbmi_pkg::MIRROR_VERT;
                        cbmi_pkg::MIR_SEL_HORIZ:  mirror_next = cbmi_pkg::MIRROR_HORIZ;
                        cbmi_pkg::MIR_SEL_LOW:    mirror_next = cbmi_pkg::MIRROR_LOW;
                        default:                  mirror_next = mirror_reg;
                    endcase
                end
                cbmi_pkg::ADDR_PRG_HIGH: prg_high_next    = in_data;
                cbmi_pkg::ADDR_CHR_0:    chr_bank_next[0] = in_data;
                cbmi_pkg::ADDR_CHR_1:    chr_bank_next[1] = in_data;
                cbmi_pkg::ADDR_CHR_2:    chr_bank_next[2] = in_data;
                cbmi_pkg::ADDR_CHR_3:    chr_bank_next[3] = in_data;
                cbmi_pkg::ADDR_CHR_4:    chr_bank_next[4] = in_data;
                cbmi_pkg::ADDR_CHR_5:    chr_bank_next[5] = in_data;
                cbmi_pkg::ADDR_CHR_6:    chr_bank_next[6] = in_data;
                cbmi_pkg::ADDR_CHR_7:    chr_bank_next[7] = in_data;
                cbmi_pkg::ADDR_IRQ_LATCH: irq_reload_next = in_data;
                cbmi_pkg::ADDR_IRQ_ACK:
                begin
                    // Acknowledge restores the enable saved in bit 0.
                    irq_mode_next  = {irq_mode_reg[0], irq_mode_reg[0]};
                    irq_level_next = 1'b0;
                end
                cbmi_pkg::ADDR_IRQ_CTRL:
                begin
                    irq_mode_next = in_data[1:0];
                    if (in_data[1])
                    begin
                        irq_count_next      = irq_reload_reg;
                        prescale_count_next = '0;
                    end
                    irq_level_next = 1'b0;
                end
                default: ;
            endcase
        end
        else if (irq_mode_reg[1])
        begin
            // Prescaler ticks the counter every period; overflow reloads and fires.
            if (prescale_sum >= cbmi_pkg::PRESCALE_PERIOD)
            begin
                prescale_count_next = prescale_sum - cbmi_pkg::PRESCALE_PERIOD;
                if (irq_count_reg == cbmi_pkg::COUNT_MAX)
                begin
                    irq_count_next = irq_reload_reg;
                    irq_level_next = 1'b1;
                end
                else
                begin
                    irq_count_next = irq_count_reg + 8'd1;
                end
            end
            else
            begin
                prescale_count_next = prescale_sum;
            end
        end
    end

    // Result beat packed from the updated state.
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = irq_level_next;
        out_data_next[8:1]   = prg_low_next;
        out_data_next[16:9]  = prg_high_next;
        out_data_next[18:17] = mirror_next;
        for (int i = 0; i < 8; i++)
        begin
            out_data_next[19 + 8*i +: 8] = chr_bank_next[i];
        end
    end

    // State registers, updated on accepted beats and configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_mode_reg       <= '0;
            irq_count_reg      <= '0;
            irq_reload_reg     <= '0;
            prescale_count_reg <= '0;
            irq_level_reg      <= 1'b0;
            prg_low_reg        <= '0;
            prg_high_reg       <= cbmi_pkg::PRG_HIGH_RESET;
            for (int i = 0; i < 8; i++)
            begin
                chr_bank_reg[i] <= 8'(i);
            end
            mirror_reg         <= cbmi_pkg::MIRROR_VERT;
        end
        else if (in_accept)
        begin
            irq_mode_reg       <= irq_mode_next;
            irq_count_reg      <= irq_count_next;
            irq_reload_reg     <= irq_reload_next;
            prescale_count_reg <= prescale_count_next;
            irq_level_reg      <= irq_level_next;
            prg_low_reg        <= prg_low_next;
            prg_high_reg       <= prg_high_next;
            chr_bank_reg       <= chr_bank_next;
            mirror_reg         <= mirror_next;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Loading the header mirroring changes only the mirroring mode.
            mirror_reg <= cfg_data ? cbmi_pkg::MIRROR_HORIZ : cbmi_pkg::MIRROR_VERT;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // The prescaler never reaches a full period between beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        prescale_count_reg < cbmi_pkg::PRESCALE_PERIOD)
        else $error("prescaler left its range");

    // The IRQ line only rises on a clock advance with counting enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_level_reg) |->
            $past(in_accept && s_tuser == cbmi_pkg::CMD_CLOCK && irq_mode_reg[1]))
        else $error("IRQ raised without a counter overflow");

    // An accepted beat always yields a result beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid)
        else $error("accepted beat produced no result");

    // A result beat carries the IRQ level held in the state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (m_tdata[0] == irq_level_reg))
        else $error("result IRQ bit disagrees with the state");

endmodule

/* test/tb_cartridge_bank_mapper_irq.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cartridge_bank_mapper_irq: bus writes and clock advances in,
// one mapping beat out per input. Depends on cbmi_pkg and the top level in rtl/.
module tb_cartridge_bank_mapper_irq;
    import cbmi_pkg::*;

    // One input beat as the driver sees it.
    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  data;
        logic [6:0]  cycles;
    } bus_beat_t;

    // One result beat, laid out exactly as m_tdata.
    typedef struct packed {
        logic [4:0]      pad;
        logic [7:0][7:0] chr;
        logic [1:0]      mirror;
        logic [7:0]      prg_c000;
        logic [7:0]      prg_16k;
        logic            irq_line;
    } bank_map_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;

    // Predicted mapper state.
    logic [1:0]      map_irq_mode;
    logic [7:0]      map_irq_count;
    logic [7:0]      map_irq_latch;
    logic [7:0]      map_prescale;
    logic            map_irq_level;
    logic [7:0]      map_prg_low;
    logic [7:0]      map_prg_high;
    logic [7:0][7:0] map_chr;
    mirror_t         map_mirror;
    logic            map_header;

    bus_beat_t pending_beats[$];
    bank_map_t expected_maps[$];
    bus_beat_t next_beat;
    bank_map_t want;
    bank_map_t got;

    int  beats_queued   = 0;
    int  beats_accepted = 0;
    int  header_writes  = 0;
    int  mismatches     = 0;
    int  writes_sent    = 0;
    int  clocks_sent    = 0;
    int  irq_results    = 0;
    int  slot;
    int  send_gap       = 0;
    int  take_wait      = 0;
    bit  send_quiet     = 1'b0;
    bit  take_quiet     = 1'b0;
    bit  in_taken       = 1'b0;
    bit  out_taken      = 1'b0;

    cartridge_bank_mapper_irq DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // Applies one accepted beat to the predicted state and returns the mapping it shows.
    function automatic bank_map_t step_mapper(input logic cmd, input logic [31:0] beat_data);
        logic [15:0] sel;
        logic [7:0]  wdata;
        logic [6:0]  steps;
        int          total;
        bank_map_t   result;
        sel   = beat_data[15:0] & ADDR_MASK;
        wdata = beat_data[23:16];
        steps = beat_data[30:24];
        if (cmd == CMD_WRITE)
        begin
            case (sel)
                ADDR_PRG_LOW:   map_prg_low  = wdata;
                ADDR_PRG_HIGH:  map_prg_high = wdata;
                ADDR_CHR_0:     map_chr[0]   = wdata;
                ADDR_CHR_1:     map_chr[1]   = wdata;
                ADDR_CHR_2:     map_chr[2]   = wdata;
                ADDR_CHR_3:     map_chr[3]   = wdata;
                ADDR_CHR_4:     map_chr[4]   = wdata;
                ADDR_CHR_5:     map_chr[5]   = wdata;
                ADDR_CHR_6:     map_chr[6]   = wdata;
                ADDR_CHR_7:     map_chr[7]   = wdata;
                ADDR_IRQ_LATCH: map_irq_latch = wdata;
                ADDR_MIRROR:
                begin
                    // Bit 7 is ignored; unknown select values keep the old mode.
                    if (wdata[6:0] == MIR_SEL_HIGH_A || wdata[6:0] == MIR_SEL_HIGH_B)
                        map_mirror = MIRROR_HIGH;
                    else if (wdata[6:0] == MIR_SEL_VERT)
                        map_mirror = MIRROR_VERT;
                    else if (wdata[6:0] == MIR_SEL_HORIZ)
                        map_mirror = MIRROR_HORIZ;
                    else if (wdata[6:0] == MIR_SEL_LOW)
                        map_mirror = MIRROR_LOW;
                end
                ADDR_IRQ_ACK:
                begin
                    // Acknowledge restores the enable from bit 0 into both bits.
                    map_irq_mode  = {2{map_irq_mode[0]}};
                    map_irq_level = 1'b0;
                end
                ADDR_IRQ_CTRL:
                begin
                    map_irq_mode = wdata[1:0];
                    if (wdata[1])
                    begin
                        map_irq_count = map_irq_latch;
                        map_prescale  = 8'd0;
                    end
                    map_irq_level = 1'b0;
                end
                default: ;
            endcase
        end
        else if (map_irq_mode[1])
        begin
            // Oversized steps are clamped so the prescaler can wrap at most once.
            if (steps > CYCLES_MAX)
                steps = CYCLES_MAX;
            total = map_prescale + steps;
            if (total >= PRESCALE_PERIOD)
            begin
                total = total - PRESCALE_PERIOD;
                if (map_irq_count == COUNT_MAX)
                begin
                    map_irq_count = map_irq_latch;
                    map_irq_level = 1'b1;
                end
                else
                    map_irq_count = map_irq_count + 8'd1;
            end
            map_prescale = 8'(total);
        end
        result.pad      = '0;
        result.chr      = map_chr;
        result.mirror   = map_mirror;
        result.prg_c000 = map_prg_high;
        result.prg_16k  = map_prg_low;
        result.irq_line = map_irq_level;
        return result;
    endfunction

    function automatic void compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function automatic void queue_beat(input logic cmd, input logic [15:0] address,
                                       input logic [7:0] data, input logic [6:0] cycles);
        bus_beat_t beat;
        beat.cmd     = cmd;
        beat.address = address;
        beat.data    = data;
        beat.cycles  = cycles;
        pending_beats.push_back(beat);
        beats_queued++;
        if (cmd == CMD_WRITE)
            writes_sent++;
        else
            clocks_sent++;
    endfunction

    // Mostly clock advances and decoded register writes, with some bus noise.
    function automatic void queue_random_beat();
        int          pick;
        logic [15:0] address;
        logic [7:0]  data;
        logic [6:0]  mir_sel;
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        if (pick < 45)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_beat(CMD_CLOCK, 16'($urandom), data, 7'($urandom_range(114, 127)));
            else
                queue_beat(CMD_CLOCK, 16'($urandom), data, 7'($urandom_range(0, 113)));
        end
        else if (pick < 88)
        begin
            case ($urandom_range(0, 14))
                0:       address = ADDR_PRG_LOW;
                1:       address = ADDR_MIRROR;
                2:       address = ADDR_PRG_HIGH;
                3:       address = ADDR_CHR_0;
                4:       address = ADDR_CHR_1;
                5:       address = ADDR_CHR_2;
                6:       address = ADDR_CHR_3;
                7:       address = ADDR_CHR_4;
                8:       address = ADDR_CHR_5;
                9:       address = ADDR_CHR_6;
                10:      address = ADDR_CHR_7;
                11:      address = ADDR_IRQ_LATCH;
                12:      address = ADDR_IRQ_ACK;
                13:      address = ADDR_IRQ_CTRL;
                default: address = 16'h9000;
            endcase
            // A latch close to the top lets the counter overflow within a short stretch.
            if (address == ADDR_IRQ_LATCH && $urandom_range(0, 3) != 0)
                data = 8'($urandom_range(8'hF8, 8'hFF));
            if (address == ADDR_IRQ_CTRL && $urandom_range(0, 3) != 0)
                data[1] = 1'b1;
            if (address == ADDR_MIRROR)
            begin
                case ($urandom_range(0, 5))
                    0:       mir_sel = MIR_SEL_VERT;
                    1:       mir_sel = MIR_SEL_HORIZ;
                    2:       mir_sel = MIR_SEL_LOW;
                    3:       mir_sel = MIR_SEL_HIGH_A;
                    4:       mir_sel = MIR_SEL_HIGH_B;
                    default: mir_sel = 7'($urandom);
                endcase
                data[6:0] = mir_sel;
            end
            // Bits outside the decode mask must not matter.
            address = address | (16'($urandom) & ~ADDR_MASK);
            queue_beat(CMD_WRITE, address, data, 7'($urandom));
        end
        else
            queue_beat(CMD_WRITE, 16'($urandom), data, 7'($urandom));
    endfunction

    // Waits until every queued beat has been taken and every result has come back.
    task automatic wait_drained();
        while (beats_accepted != beats_queued || expected_maps.size() != 0)
            @(negedge clk);
    endtask

    // Writes the header mirroring register; called at a falling edge while idle.
    task automatic write_header(input logic value);
        int seen;
        seen = header_writes;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        while (header_writes == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: presents queued beats with a random gap after each one.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                next_beat = pending_beats.pop_front();
                s_tuser  <= next_beat.cmd;
                s_tdata  <= {1'b0, next_beat.cycles, next_beat.data, next_beat.address};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, 7);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure: a random stall before each result beat.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                if ($urandom_range(0, 39) == 0)
                    take_quiet = !take_quiet;
                take_wait = take_quiet ? 0 : $urandom_range(0, 7);
            end
            if (take_wait > 0)
            begin
                take_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: tracks handshakes, updates the prediction and checks result beats.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            map_irq_mode  = 2'd0;
            map_irq_count = 8'd0;
            map_irq_latch = 8'd0;
            map_prescale  = 8'd0;
            map_irq_level = 1'b0;
            map_prg_low   = 8'd0;
            map_prg_high  = PRG_HIGH_RESET;
            for (slot = 0; slot < 8; slot++)
                map_chr[slot] = 8'(slot);
            map_header = 1'b0;
            map_mirror = MIRROR_VERT;
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (cfg_valid && cfg_ready)
            begin
                map_header = cfg_data;
                map_mirror = cfg_data ? MIRROR_HORIZ : MIRROR_VERT;
                header_writes++;
            end
            // Results are checked before this edge's input is predicted.
            if (m_tvalid && m_tready)
            begin
                if (expected_maps.size() == 0)
                begin
                    $error("unexpected result beat: m_tdata %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_maps.pop_front();
                    got  = bank_map_t'(m_tdata);
                    compare_field("irq_line", want.irq_line, got.irq_line);
                    compare_field("prg_bank_16k", want.prg_16k, got.prg_16k);
                    compare_field("prg_bank_c000", want.prg_c000, got.prg_c000);
                    compare_field("mirror_mode", want.mirror, got.mirror);
                    for (slot = 0; slot < 8; slot++)
                        compare_field($sformatf("chr_bank_%c", 8'h61 + slot),
                                      want.chr[slot], got.chr[slot]);
                    if (want.irq_line)
                        irq_results++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_maps.push_back(step_mapper(s_tuser, s_tdata));
                beats_accepted++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_header(1'b1);

        // Directed: counting off, every register, mirroring selects, ignored writes.
        queue_beat(CMD_CLOCK, 16'hFFFF, 8'hFF, 7'd127);
        queue_beat(CMD_WRITE, 16'h8FFC, 8'hFF, 7'd0);
        queue_beat(CMD_WRITE, ADDR_PRG_HIGH, 8'h00, 7'd0);
        queue_beat(CMD_WRITE, ADDR_PRG_HIGH, 8'hFF, 7'd127);
        queue_beat(CMD_WRITE, ADDR_CHR_0, 8'hFF, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_2, 8'h00, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_1, 8'h80, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_3, 8'h7F, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_4, 8'h01, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_6, 8'hFE, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_5, 8'hAA, 7'd0);
        queue_beat(CMD_WRITE, ADDR_CHR_7, 8'h55, 7'd0);
        queue_beat(CMD_WRITE, ADDR_MIRROR, {1'b0, MIR_SEL_VERT}, 7'd0);
        queue_beat(CMD_WRITE, ADDR_MIRROR, {1'b0, MIR_SEL_LOW}, 7'd0);
        queue_beat(CMD_WRITE, ADDR_MIRROR, {1'b1, MIR_SEL_HORIZ}, 7'd0);
        queue_beat(CMD_WRITE, ADDR_MIRROR, {1'b0, MIR_SEL_HIGH_A}, 7'd0);
        queue_beat(CMD_WRITE, ADDR_MIRROR, {1'b1, MIR_SEL_HIGH_B}, 7'd0);
        queue_beat(CMD_WRITE, ADDR_MIRROR, 8'h55, 7'd0);
        queue_beat(CMD_WRITE, 16'h9000, 8'h12, 7'd0);
        queue_beat(CMD_WRITE, 16'h7FFF, 8'hFF, 7'd0);
        // Latch at the top, enable, then overflow on the second advance.
        queue_beat(CMD_WRITE, ADDR_IRQ_LATCH, 8'hFF, 7'd0);
        queue_beat(CMD_WRITE, ADDR_IRQ_CTRL, 8'h03, 7'd0);
        queue_beat(CMD_CLOCK, 16'h0000, 8'h00, 7'd113);
        queue_beat(CMD_CLOCK, 16'h0000, 8'h00, 7'd1);
        queue_beat(CMD_WRITE, ADDR_IRQ_ACK, 8'h00, 7'd0);
        queue_beat(CMD_CLOCK, 16'hFFFF, 8'hFF, 7'd127);
        queue_beat(CMD_WRITE, ADDR_IRQ_CTRL, 8'h00, 7'd0);
        queue_beat(CMD_CLOCK, 16'h0000, 8'h00, 7'd50);
        wait_drained();

        // Random phases, alternating the header mirroring between them.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_header(phase[0]);
            repeat (300) queue_random_beat();
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("tb: %0d beats sent (%0d register writes, %0d clock advances), %0d header writes",
                 beats_queued, writes_sent, clocks_sent, header_writes);
        $display("tb: %0d results carried an asserted IRQ line", irq_results);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
